// ===== rtl/lksc_pkg.sv =====
// ----------------------------------------------------------------------------
// lksc_pkg
// Shared constants for the keyed slot cache.
// ----------------------------------------------------------------------------
package lksc_pkg;
   localparam int MaxEntries    = 128;
   localparam int KeyWidth      = 64;
   localparam int MaskWidth     = 23;
   localparam int LimitWidth    = 8;
   localparam logic [LimitWidth-1:0] LimitReset = 8'd100;
   localparam logic [0:0] RegCapacityLimit = 1'b0;
endpackage

// ===== rtl/lksc_req_if.sv =====
// ----------------------------------------------------------------------------
// lksc_req_if
// Request channel: key and attribute mask.
// ----------------------------------------------------------------------------
interface lksc_req_if import lksc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KeyWidth-1:0]  value_key;
   logic [MaskWidth-1:0] attr_mask;
   modport source (output valid, value_key, attr_mask, input ready);
   modport sink (input valid, value_key, attr_mask, output ready);
endinterface

// ===== rtl/lksc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lksc_rsp_if
// Response channel: hit, slot, eviction and occupancy.
// ----------------------------------------------------------------------------
interface lksc_rsp_if #(parameter int SlotWidth = 7, parameter int CountWidth = 8) ();
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [SlotWidth-1:0]  slot;
   logic                  evicted;
   logic [CountWidth-1:0] occupancy;
   modport source (output valid, hit, slot, evicted, occupancy, input ready);
   modport sink (input valid, hit, slot, evicted, occupancy, output ready);
endinterface

// ===== rtl/lru_keyed_slot_cache_unit.sv =====
// ----------------------------------------------------------------------------
// lru_keyed_slot_cache_unit
// Fully associative LRU cache of keyed slots with memory-based link lists.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake      Payload
// req       in   valid/ready    value_key, attr_mask
// rsp       out  valid/ready    hit, slot, evicted, occupancy
// csr       in   APB write/read capacity_limit at address 0
// An item passes through the scan (one entry read per cycle from the key
// memory), a decision step, the link reads and writes where needed (StRdNw,
// StRdOd, StWrOd, StWrNw, StApp) and an output step before its result is valid.
// Reset is synchronous; no clearing pass is needed, entries are read only
// below the fill count. The result is held until taken; the next item is
// accepted only once the result register is free.
// ----------------------------------------------------------------------------
module lru_keyed_slot_cache_unit import lksc_pkg::*; #(
   parameter int MAX_ENTRIES = MaxEntries
) (
   input  logic clock,
   input  logic reset,
   lksc_req_if.sink req,
   lksc_rsp_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int SW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [CW-1:0] MaxCount = CW'(MAX_ENTRIES);

   localparam logic [3:0] StIdle = 4'd0, StScan = 4'd1, StDecide = 4'd2,
      StRdNw = 4'd3, StRdOd = 4'd4, StWrOd = 4'd5, StWrNw = 4'd6,
      StApp = 4'd7, StOut = 4'd8;

   logic [KeyWidth+MaskWidth-1:0] ent_mem [MAX_ENTRIES];
   logic [SW-1:0] older_mem [MAX_ENTRIES];
   logic [SW-1:0] newer_mem [MAX_ENTRIES];

   logic [3:0] state_ff, state_in;
   logic [LimitWidth-1:0] limit_ff;
   logic [SW-1:0] lru_ff, lru_in, mru_ff, mru_in;
   logic [CW-1:0] count_ff, count_in;
   logic [KeyWidth+MaskWidth-1:0] key_ff, key_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic rd_pend_ff, rd_pend_in;
   logic [SW-1:0] slot_ff, slot_in, nw_ff, nw_in;
   logic hit_ff, hit_in, ev_ff, ev_in;
   logic out_v_ff, out_v_in;

   logic [KeyWidth+MaskWidth-1:0] ent_rd_ff;
   logic [SW-1:0] older_rd_ff, newer_rd_ff;
   logic ent_we, old_we, new_we;
   logic [SW-1:0] ent_ra, ent_wa, old_a, old_wd, new_a, new_wd;
   logic [CW-1:0] eff_lim, n_cnt;

   assign csr_pready = 1'b1;
   assign csr_prdata = {{(32-LimitWidth){1'b0}}, limit_ff};

   always_comb begin
      eff_lim = (limit_ff == '0) ? CW'(1) : CW'(limit_ff);
      if (CW'(limit_ff) > MaxCount || (LimitWidth > CW && limit_ff > LimitWidth'(MAX_ENTRIES)))
         eff_lim = MaxCount;
      n_cnt = (count_ff > MaxCount) ? MaxCount : count_ff;
   end

   always_comb begin
      state_in = state_ff; lru_in = lru_ff; mru_in = mru_ff; count_in = count_ff;
      key_in = key_ff; idx_in = idx_ff; rd_pend_in = 1'b0; slot_in = slot_ff;
      nw_in = nw_ff; hit_in = hit_ff; ev_in = ev_ff; out_v_in = out_v_ff;
      ent_we = 1'b0; old_we = 1'b0; new_we = 1'b0;
      ent_ra = idx_ff[SW-1:0]; ent_wa = slot_ff;
      old_a = slot_ff; old_wd = mru_ff; new_a = slot_ff; new_wd = slot_ff;
      if (rsp.ready) out_v_in = 1'b0;
      case (state_ff)
         StIdle: begin
            idx_in = '0;
            if (req.valid && !out_v_ff) begin
               key_in = {req.value_key, req.attr_mask};
               state_in = StScan;
            end
         end
         StScan: begin
            if (rd_pend_ff && ent_rd_ff == key_ff) begin
               slot_in = SW'(idx_ff - CW'(1)); hit_in = 1'b1; ev_in = 1'b0;
               state_in = StDecide;
            end else if (idx_ff == n_cnt) begin
               hit_in = 1'b0; state_in = StDecide;
            end else begin
               rd_pend_in = 1'b1; idx_in = idx_ff + CW'(1);
            end
         end
         StDecide: begin
            if (hit_ff) begin
               state_in = (slot_ff == mru_ff) ? StOut : StRdNw;
            end else if (n_cnt >= eff_lim && n_cnt != '0) begin
               ev_in = 1'b1; slot_in = lru_ff; ent_wa = lru_ff; ent_we = 1'b1;
               state_in = (lru_ff == mru_ff) ? StOut : StRdNw;
            end else begin
               ev_in = 1'b0; slot_in = SW'(n_cnt); ent_wa = SW'(n_cnt); ent_we = 1'b1;
               count_in = n_cnt + CW'(1);
               if (n_cnt == '0) begin
                  lru_in = '0; mru_in = '0; state_in = StOut;
               end else state_in = StApp;
            end
         end
         StRdNw: state_in = StRdOd;
         StRdOd: begin
            nw_in = newer_rd_ff;
            if (slot_ff == lru_ff) begin
               lru_in = newer_rd_ff; state_in = StApp;
            end else state_in = StWrOd;
         end
         StWrOd: begin
            new_a = older_rd_ff; new_wd = nw_ff; new_we = 1'b1;
            state_in = StWrNw;
         end
         StWrNw: begin
            old_a = nw_ff; old_wd = older_rd_ff; old_we = 1'b1;
            state_in = StApp;
         end
         StApp: begin
            old_a = slot_ff; old_wd = mru_ff; old_we = 1'b1;
            new_a = mru_ff; new_wd = slot_ff; new_we = 1'b1;
            mru_in = slot_ff; state_in = StOut;
         end
         StOut: begin
            out_v_in = 1'b1; state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_wa] <= key_ff;
      ent_rd_ff <= ent_mem[ent_ra];
      if (old_we) older_mem[old_a] <= old_wd;
      older_rd_ff <= older_mem[old_a];
      if (new_we) newer_mem[new_a] <= new_wd;
      newer_rd_ff <= newer_mem[new_a];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle; limit_ff <= LimitReset; lru_ff <= '0; mru_ff <= '0;
         count_ff <= '0; out_v_ff <= 1'b0; rd_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; lru_ff <= lru_in; mru_ff <= mru_in;
         count_ff <= count_in; out_v_ff <= out_v_in; rd_pend_ff <= rd_pend_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == {RegCapacityLimit, 1'b0})
            limit_ff <= csr_pwdata[LimitWidth-1:0];
      end
      key_ff <= key_in; idx_ff <= idx_in; slot_ff <= slot_in; nw_ff <= nw_in;
      hit_ff <= hit_in; ev_ff <= ev_in;
   end

   assign req.ready     = (state_ff == StIdle) && !out_v_ff;
   assign rsp.valid     = out_v_ff;
   assign rsp.hit       = hit_ff;
   assign rsp.slot      = slot_ff;
   assign rsp.evicted   = ev_ff;
   assign rsp.occupancy = count_ff;
endmodule
